// ===== hw/rtl/grid_mesh_face_filter_core_assert.svh =====
// Assertion helpers for the face filter. Users need clk_i and rst_ni in scope.
`ifndef GRID_MESH_FACE_FILTER_CORE_ASSERT_SVH
`define GRID_MESH_FACE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GMFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GMFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gmff_pkg.sv =====
package gmff_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned ORD_W      = 21;

  localparam logic [DIM_W-1:0] GRID_WIDTH_RST     = 11'd640;
  localparam logic [DIM_W-1:0] GRID_HEIGHT_RST    = 11'd480;
  localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0] first_vertex;
    logic [IDX_W-1:0] second_vertex;
    logic [IDX_W-1:0] third_vertex;
    logic [ORD_W-1:0] face_ordinal;
    logic             last_in_run;
  } face_t;

  typedef struct packed {
    logic  both;
    face_t first;
    face_t second;
  } face_pair_t;

endpackage

// ===== hw/rtl/gmff_if.sv =====
interface gmff_vtx_if #(
  parameter int unsigned CoordBits = 18
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] pos_x;
  logic signed [CoordBits-1:0] pos_y;
  logic signed [CoordBits-1:0] pos_z;
  logic                        point_valid;
  logic                        frame_start;

  modport source (
    output valid, pos_x, pos_y, pos_z, point_valid, frame_start,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, point_valid, frame_start,
    output ready
  );
endinterface

interface gmff_face_if;
  logic                        valid;
  logic                        ready;
  logic [gmff_pkg::IDX_W-1:0]  first_vertex;
  logic [gmff_pkg::IDX_W-1:0]  second_vertex;
  logic [gmff_pkg::IDX_W-1:0]  third_vertex;
  logic [gmff_pkg::ORD_W-1:0]  face_ordinal;
  logic                        last_in_run;

  modport source (
    output valid, first_vertex, second_vertex, third_vertex, face_ordinal, last_in_run,
    input  ready
  );
  modport sink (
    input  valid, first_vertex, second_vertex, third_vertex, face_ordinal, last_in_run,
    output ready
  );
endinterface

// ===== hw/rtl/gmff_line_buf.sv =====
// Previous-row store: one port, read-first, registered read data.
module gmff_line_buf #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 55
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gmff_edge_len.sv =====
// Edge length test in two register stages: |delta| per axis, then squares.
// ok_o is the final sum-and-compare on the second stage.
module gmff_edge_len #(
  parameter int unsigned CoordBits = 18
) (
  input  logic                           clk_i,
  input  logic                           en_a_i,
  input  logic                           en_b_i,
  input  logic [3*CoordBits-1:0]         a_i,
  input  logic [3*CoordBits-1:0]         b_i,
  input  logic [gmff_pkg::THR_W-1:0]     thr_i,
  input  logic [2*gmff_pkg::THR_W-1:0]   thr_sq_i,
  output logic                           ok_o
);

  localparam int unsigned ThrW  = gmff_pkg::THR_W;
  localparam int unsigned DiffW = CoordBits + 1;
  localparam int unsigned CmpW  = (DiffW > ThrW) ? DiffW : ThrW;
  localparam int unsigned SqW   = 2 * ThrW;
  localparam int unsigned SumW  = SqW + 2;

  logic signed [DiffW-1:0] diff [3];
  logic        [DiffW-1:0] mag  [3];
  logic        [2:0]       over;
  logic        [ThrW-1:0]  mag_q [3];
  logic                    over_a_q;
  logic        [SqW-1:0]   sq_q [3];
  logic                    over_b_q;
  logic        [SumW-1:0]  sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = DiffW'(signed'(a_i[k*CoordBits +: CoordBits]))
              - DiffW'(signed'(b_i[k*CoordBits +: CoordBits]));
      mag[k]  = diff[k][DiffW-1] ? unsigned'(-diff[k]) : unsigned'(diff[k]);
      over[k] = CmpW'(mag[k]) > CmpW'(thr_i);
    end
  end

  // Once no axis exceeds the threshold, each delta fits the threshold width.
  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= ThrW'(mag[k]);
      end
      over_a_q <= |over;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= mag_q[k] * mag_q[k];
      end
      over_b_q <= over_a_q;
    end
  end

  assign sum  = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  assign ok_o = !over_b_q && (sum <= SumW'(thr_sq_i));

endmodule

// ===== hw/rtl/gmff_face_out.sv =====
`include "grid_mesh_face_filter_core_assert.svh"

// Two-slot face buffer in front of the output register; drains one face per beat.
module gmff_face_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gmff_pkg::face_pair_t pair_i,
  output logic                 rdy_o,
  gmff_face_if.source          face_o
);

  logic [1:0]      cnt_q;
  logic [1:0]      cnt_d;
  gmff_pkg::face_t slot0_q;
  gmff_pkg::face_t slot1_q;
  gmff_pkg::face_t out_q;
  logic            ov_q;
  logic            out_free;
  logic            pop;

  assign out_free = !ov_q || face_o.ready;
  assign pop      = out_free && (cnt_q != 2'd0);
  assign rdy_o    = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_free);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) begin
      cnt_d = pair_i.both ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (out_free) begin
        ov_q <= (cnt_q != 2'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot0_q <= pair_i.first;
      slot1_q <= pair_i.second;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
    if (pop) begin
      out_q <= slot0_q;
    end
  end

  assign face_o.valid         = ov_q;
  assign face_o.first_vertex  = out_q.first_vertex;
  assign face_o.second_vertex = out_q.second_vertex;
  assign face_o.third_vertex  = out_q.third_vertex;
  assign face_o.face_ordinal  = out_q.face_ordinal;
  assign face_o.last_in_run   = out_q.last_in_run;

  `GMFF_ASSERT_IMP(a_push_room, push_i, rdy_o, "face pair pushed without room")
  `GMFF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3, "face buffer count out of range")
  // While the first of two faces waits on the port, its partner is still buffered.
  `GMFF_ASSERT_IMP(a_partner_held, ov_q && !out_q.last_in_run, cnt_q != 2'd0,
                   "first face of a pair shown without its partner buffered")
  `GMFF_ASSERT_NXT(a_pair_loaded, push_i && pair_i.both,
                   cnt_q == 2'd2 && slot1_q == $past(pair_i.second),
                   "second face of a pair not captured")

endmodule

// ===== hw/rtl/grid_mesh_face_filter_core.sv =====
// Grid mesh face filter.
// vtx_i takes one grid vertex per beat in raster order (frame_start forces
// row 0, column 0). face_o gives the surviving triangles of each grid cell as
// three linear vertex indices plus a per-frame ordinal; last_in_run marks the
// last face caused by a vertex. Both channels use valid/ready.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (grid width,
// grid height, edge threshold); write only while no vertex is in flight.
// Path: a vertex passes stages 1 to 3, then the face buffer's output register
// shows its face; a cell's second face follows. Throughput: one vertex per
// cycle while face_o does not stall and cells give at most one face; slower
// when both pass, the bound being the single face port draining a two-slot buffer.
// The row store is a one-port memory of MAX_WIDTH entries, read and written
// once per accepted vertex; the rest of the path is a 3-stage pipeline.
// Reset clears counters and pipeline valids and loads register defaults; the
// row store is not cleared, so the first row of a frame forms no cells.
// A stall on face_o backs up through the face buffer and the pipeline until
// vtx_i.ready drops; nothing is lost or repeated.
module grid_mesh_face_filter_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned COORD_BITS = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gmff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gmff_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gmff_vtx_if.sink                        vtx_i,
  gmff_face_if.source                     face_o
);

  localparam int unsigned DimW = gmff_pkg::DIM_W;
  localparam int unsigned ThrW = gmff_pkg::THR_W;
  localparam int unsigned IdxW = gmff_pkg::IDX_W;
  localparam int unsigned OrdW = gmff_pkg::ORD_W;
  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned WdW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HtW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CrdW = 3 * COORD_BITS;
  localparam int unsigned VtxW = CrdW + 1;
  localparam int unsigned PrdW = RowW + WdW;
  localparam int unsigned NumEdges = 5;

  // Edge slots: the diagonal TL-BR is shared by both triangles.
  localparam int unsigned E_TL_TR = 0;
  localparam int unsigned E_TR_BR = 1;
  localparam int unsigned E_TL_BR = 2;
  localparam int unsigned E_BR_BL = 3;
  localparam int unsigned E_TL_BL = 4;

  // ---------------- configuration ----------------
  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [ThrW-1:0]   thr_q;
  logic [2*ThrW-1:0] thr_sq_q;
  logic [WdW-1:0]    w_eff;
  logic [HtW-1:0]    h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gmff_pkg::GRID_WIDTH_RST;
      height_q <= gmff_pkg::GRID_HEIGHT_RST;
      thr_q    <= gmff_pkg::EDGE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (gmff_pkg::cfg_reg_e'(cfg_idx_i))
        gmff_pkg::REG_GRID_WIDTH:     width_q  <= cfg_data_i[DimW-1:0];
        gmff_pkg::REG_GRID_HEIGHT:    height_q <= cfg_data_i[DimW-1:0];
        gmff_pkg::REG_EDGE_THRESHOLD: thr_q    <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= thr_q * thr_q;
  end

  always_comb begin
    if (32'(width_q) < 32'd2) begin
      w_eff = WdW'(2);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WdW'(MAX_WIDTH);
    end else begin
      w_eff = WdW'(width_q);
    end
    if (32'(height_q) < 32'd2) begin
      h_eff = HtW'(2);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HtW'(MAX_HEIGHT);
    end else begin
      h_eff = HtW'(height_q);
    end
  end

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic pair_rdy;
  logic acc;
  logic adv1;
  logic adv3;

  assign rdy3        = !v3_q || pair_rdy;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign vtx_i.ready = rdy1;
  assign acc         = vtx_i.valid && rdy1;
  assign adv1        = v1_q && rdy2;
  assign adv3        = v3_q && pair_rdy;

  // ---------------- grid position ----------------
  logic [ColW-1:0] col_cnt_q, col_cnt_d, col_in;
  logic [RowW-1:0] row_cnt_q, row_cnt_d, row_in;
  logic [VtxW-1:0] cur_in;

  assign col_in = vtx_i.frame_start ? '0 : col_cnt_q;
  assign row_in = vtx_i.frame_start ? '0 : row_cnt_q;
  assign cur_in = {vtx_i.point_valid, vtx_i.pos_x, vtx_i.pos_y, vtx_i.pos_z};

  always_comb begin
    col_cnt_d = col_in + ColW'(1);
    row_cnt_d = row_in;
    if (WdW'(col_in) + WdW'(1) >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (HtW'(row_in) + HtW'(1) >= h_eff) ? '0 : row_in + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (acc) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // ---------------- stage 1: row store read, corner vertices ----------------
  logic [VtxW-1:0] tr_v;
  logic [VtxW-1:0] cur1_q;
  logic [ColW-1:0] col1_q;
  logic [RowW-1:0] row1_q;
  logic            clr1_q;
  logic            cell1_q;
  logic [VtxW-1:0] tl_q;
  logic [VtxW-1:0] bl_q;
  logic            tri_a_valid;
  logic            tri_b_valid;
  logic [PrdW-1:0] row_base;

  gmff_line_buf #(
    .Depth (MAX_WIDTH),
    .Width (VtxW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (acc),
    .addr_i  (col_in),
    .wdata_i (cur_in),
    .rdata_o (tr_v)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cur1_q  <= cur_in;
      col1_q  <= col_in;
      row1_q  <= row_in;
      clr1_q  <= (col_in == '0) && (row_in == '0);
      cell1_q <= (col_in != '0) && (row_in != '0);
    end
    // Top-left is last beat's top-right; bottom-left is last beat's vertex.
    if (adv1) begin
      tl_q <= tr_v;
      bl_q <= cur1_q;
    end
  end

  assign tri_a_valid = cell1_q && tl_q[VtxW-1] && tr_v[VtxW-1] && cur1_q[VtxW-1];
  assign tri_b_valid = cell1_q && tl_q[VtxW-1] && cur1_q[VtxW-1] && bl_q[VtxW-1];
  assign row_base    = row1_q * w_eff;

  logic [CrdW-1:0]     edge_a [NumEdges];
  logic [CrdW-1:0]     edge_b [NumEdges];
  logic [NumEdges-1:0] edge_ok;

  always_comb begin
    edge_a[E_TL_TR] = tl_q[CrdW-1:0];   edge_b[E_TL_TR] = tr_v[CrdW-1:0];
    edge_a[E_TR_BR] = tr_v[CrdW-1:0];   edge_b[E_TR_BR] = cur1_q[CrdW-1:0];
    edge_a[E_TL_BR] = tl_q[CrdW-1:0];   edge_b[E_TL_BR] = cur1_q[CrdW-1:0];
    edge_a[E_BR_BL] = cur1_q[CrdW-1:0]; edge_b[E_BR_BL] = bl_q[CrdW-1:0];
    edge_a[E_TL_BL] = tl_q[CrdW-1:0];   edge_b[E_TL_BL] = bl_q[CrdW-1:0];
  end

  for (genvar g = 0; g < NumEdges; g++) begin : g_edge
    gmff_edge_len #(
      .CoordBits (COORD_BITS)
    ) u_edge_len (
      .clk_i    (clk_i),
      .en_a_i   (rdy2),
      .en_b_i   (rdy3),
      .a_i      (edge_a[g]),
      .b_i      (edge_b[g]),
      .thr_i    (thr_q),
      .thr_sq_i (thr_sq_q),
      .ok_o     (edge_ok[g])
    );
  end

  // ---------------- stage 2: vertex indices ----------------
  logic [IdxW-1:0] rb2_q;
  logic [ColW-1:0] col2_q;
  logic            clr2_q, va2_q, vb2_q;
  logic [IdxW-1:0] ibl2, itl2;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      rb2_q  <= IdxW'(row_base);
      col2_q <= col1_q;
      clr2_q <= clr1_q;
      va2_q  <= tri_a_valid;
      vb2_q  <= tri_b_valid;
    end
  end

  assign ibl2 = rb2_q + IdxW'(col2_q) - IdxW'(1);
  assign itl2 = ibl2 - IdxW'(w_eff);

  // ---------------- stage 3: triangle decision, face numbering ----------------
  logic [IdxW-1:0]      itl3_q, ibl3_q;
  logic                 clr3_q, va3_q, vb3_q;
  logic                 ok_a, ok_b;
  logic [1:0]           n_faces;
  logic [OrdW-1:0]      face_cnt_q;
  gmff_pkg::face_t      face_a, face_b;
  gmff_pkg::face_pair_t pair;
  logic                 push;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      itl3_q <= itl2;
      ibl3_q <= ibl2;
      clr3_q <= clr2_q;
      va3_q  <= va2_q;
      vb3_q  <= vb2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= vtx_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign ok_a = va3_q && edge_ok[E_TL_TR] && edge_ok[E_TR_BR] && edge_ok[E_TL_BR];
  assign ok_b = vb3_q && edge_ok[E_TL_BR] && edge_ok[E_BR_BL] && edge_ok[E_TL_BL];
  assign n_faces = {1'b0, ok_a} + {1'b0, ok_b};
  assign push    = adv3 && (ok_a || ok_b);

  always_comb begin
    face_a.first_vertex  = itl3_q;
    face_a.second_vertex = itl3_q + IdxW'(1);
    face_a.third_vertex  = ibl3_q + IdxW'(1);
    face_a.face_ordinal  = face_cnt_q + OrdW'(1);
    face_a.last_in_run   = !ok_b;

    face_b.first_vertex  = itl3_q;
    face_b.second_vertex = ibl3_q + IdxW'(1);
    face_b.third_vertex  = ibl3_q;
    face_b.face_ordinal  = face_cnt_q + (ok_a ? OrdW'(2) : OrdW'(1));
    face_b.last_in_run   = 1'b1;

    pair.both   = ok_a && ok_b;
    pair.first  = ok_a ? face_a : face_b;
    pair.second = face_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_cnt_q <= '0;
    end else if (adv3) begin
      face_cnt_q <= clr3_q ? '0 : face_cnt_q + OrdW'(n_faces);
    end
  end

  gmff_face_out u_face_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pair_i (pair),
    .rdy_o  (pair_rdy),
    .face_o (face_o)
  );

endmodule
